### src/srb_pkg.sv
// Shared types and constants for the sequence reorder buffer.
// No dependencies; imported by sequence_reorder_buffer_unit.
package srb_pkg;

	localparam int SEQ_W     = 32;
	localparam int TAG_W     = 4;
	localparam int DEPTH_DEF = 16;

	// One held entry of the store
	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [TAG_W-1:0] tag;
		logic             end_mark;
	} entry_t;

	// One result word, without its last flag
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [SEQ_W-1:0] seq;
		logic             end_mark;
		logic             status;
	} res_t;

	localparam logic ST_RELEASED = 1'b0;
	localparam logic ST_OVERFLOW = 1'b1;

endpackage

### src/sequence_reorder_buffer_unit.sv
// Reorder buffer: sorted store in one synchronous RAM with in-order release.
// Depends on srb_pkg for entry and result types.
// An item walks down, moving each held entry it passes up one place, and is placed (at
// once into an empty store); release sends the top entry while it holds the next expected
// number, then flushes the last word. Overflow presents the dropped word. One item at a
// time, set by the insertion walk and release run through the RAM. Reset clears control
// state only; RAM entries above the fill count are never read, so the RAM needs no clearing.
module sequence_reorder_buffer_unit
	import srb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [SEQ_W-1:0] seq_num,
	input  logic [TAG_W-1:0] tag,
	input  logic             end_marker,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [TAG_W-1:0] out_tag,
	output logic [SEQ_W-1:0] out_seq,
	output logic             out_end,
	output logic             status,
	output logic             last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);
	localparam logic [CW-1:0] ONE  = CW'(1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SHIFT = 6'b000010,
		ST_PLACE = 6'b000100,
		ST_RD    = 6'b001000,
		ST_CHK   = 6'b010000,
		ST_FLUSH = 6'b100000
	} state_t;

	// Store
	entry_t mem [DEPTH];
	entry_t rd_data_q;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;

	// Control and working registers
	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [AW-1:0]   pos_q, pos_d;
	logic [SEQ_W-1:0] next_q, next_d;
	logic            stopped_q, stopped_d;
	entry_t          new_q, new_d;
	res_t            pend_q, pend_d;
	logic            pend_v_q, pend_v_d;
	res_t            out_q;
	logic            out_last_q;
	logic            out_valid_q;

	logic            accept;
	logic            out_free;
	logic            push;
	logic            push_last;
	logic [AW-1:0]   pos_m1;
	logic [CW-1:0]   cnt_m1;
	logic [CW-1:0]   cnt_m2;
	logic            match;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign pos_m1   = pos_q - AW'(1);
	assign cnt_m1   = cnt_q - ONE;
	assign cnt_m2   = cnt_q - CW'(2);
	assign match    = (rd_data_q.seq == next_q);

	// Sequencer: insertion walk, then release from the top
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		next_d    = next_q;
		stopped_d = stopped_q;
		new_d     = new_q;
		pend_d    = pend_q;
		pend_v_d  = pend_v_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = new_q;
		push      = 1'b0;
		push_last = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept && !stopped_q) begin
					new_d = '{seq: seq_num, tag: tag, end_mark: end_marker};
					if (cnt_q == FULL) begin
						// Drop the word and report overflow
						pend_d   = '{tag: tag, seq: seq_num, end_mark: end_marker,
							status: ST_OVERFLOW};
						pend_v_d = 1'b1;
						state_d  = ST_FLUSH;
					end else if (cnt_q == '0) begin
						wr_en   = 1'b1;
						wr_addr = '0;
						wr_data = '{seq: seq_num, tag: tag, end_mark: end_marker};
						cnt_d   = ONE;
						state_d = ST_RD;
					end else begin
						pos_d   = cnt_q[AW-1:0];
						rd_en   = 1'b1;
						rd_addr = cnt_m1[AW-1:0];
						state_d = ST_SHIFT;
					end
				end
			end
			ST_SHIFT: begin
				if (new_q.seq >= rd_data_q.seq) begin
					// Move the held entry one place up
					wr_en   = 1'b1;
					wr_addr = pos_q;
					wr_data = rd_data_q;
					pos_d   = pos_m1;
					if (pos_m1 == '0) begin
						state_d = ST_PLACE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = pos_m1 - AW'(1);
					end
				end else begin
					wr_en   = 1'b1;
					wr_addr = pos_q;
					cnt_d   = cnt_q + ONE;
					state_d = ST_RD;
				end
			end
			ST_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				cnt_d   = cnt_q + ONE;
				state_d = ST_RD;
			end
			ST_RD: begin
				rd_en   = 1'b1;
				rd_addr = cnt_m1[AW-1:0];
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (cnt_q != '0 && match) begin
					if (!pend_v_q || out_free) begin
						// Send the previous word; it is not the last
						push      = pend_v_q;
						push_last = 1'b0;
						pend_d    = '{tag: rd_data_q.tag, seq: rd_data_q.seq,
							end_mark: rd_data_q.end_mark, status: ST_RELEASED};
						pend_v_d  = 1'b1;
						cnt_d     = cnt_m1;
						if (rd_data_q.end_mark) begin
							stopped_d = 1'b1;
							state_d   = ST_FLUSH;
						end else begin
							next_d = next_q + SEQ_W'(1);
							if (cnt_q == ONE) begin
								state_d = ST_FLUSH;
							end else begin
								rd_en   = 1'b1;
								rd_addr = cnt_m2[AW-1:0];
							end
						end
					end
				end else if (pend_v_q) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					pend_v_d  = 1'b0;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			next_q      <= '0;
			stopped_q   <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			next_q    <= next_d;
			stopped_q <= stopped_d;
			pend_v_q  <= pend_v_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		new_q  <= new_d;
		pend_q <= pend_d;
		if (push) begin
			out_q      <= pend_q;
			out_last_q <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_tag   = out_q.tag;
	assign out_seq   = out_q.seq;
	assign out_end   = out_q.end_mark;
	assign status    = out_q.status;
	assign last      = out_last_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL)
		else $error("fill count beyond depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result word overwritten before it was taken");

	a_stopped_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q && state_q == ST_IDLE |=> !pend_v_q && state_q == ST_IDLE)
		else $error("activity after end of stream");

	a_shift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> pos_q != '0 && CW'(pos_q) <= cnt_q)
		else $error("insertion walk out of range");

endmodule
